### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the stack machine.
// Included by bare file name; holds defines only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is asserted.
`define BSM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true out of reset.
`define BSM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `BSM_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

### hdl/bsm_pkg.sv
// Package for the bytecode stack machine: sizes, opcodes, status codes,
// state types and the request/response structs of the arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package bsm_pkg;

  localparam int unsigned STACK_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = ADDR_W + 1;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned DIV_STEPS   = DATA_W;
  localparam int unsigned DCNT_W      = $clog2(DIV_STEPS + 1);

  localparam logic [CNT_W-1:0] STACK_FULL = CNT_W'(STACK_DEPTH);

  // opcodes
  localparam logic [7:0] OP_NOP  = 8'd0;
  localparam logic [7:0] OP_ADD  = 8'd1;
  localparam logic [7:0] OP_SUB  = 8'd2;
  localparam logic [7:0] OP_MUL  = 8'd3;
  localparam logic [7:0] OP_DIV  = 8'd4;
  localparam logic [7:0] OP_POW  = 8'd5;
  localparam logic [7:0] OP_NEG  = 8'd6;
  localparam logic [7:0] OP_LIT  = 8'd7;
  localparam logic [7:0] OP_HALT = 8'd8;

  // result status
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_BADOP = 3'd4;

  // literal bytes still to collect
  localparam logic [2:0] LIT_BYTES = 3'd4;

  typedef enum logic [2:0] {
    ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_POW, ALU_NEG
  } alu_op_e;

  typedef enum logic [1:0] {
    ALU_IDLE, ALU_DIV_RUN, ALU_POW_RUN, ALU_DONE
  } alu_state_e;

  typedef enum logic [2:0] {
    S_IDLE, S_RD_B, S_RD_A, S_GET_A, S_START, S_EXEC, S_EMIT
  } ctl_state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic              divz;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage
`default_nettype wire

### hdl/bsm_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bsm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### hdl/bsm_alu.sv
// Arithmetic unit: add/sub/neg/mul computed at start, radix-2 divider (32 steps),
// square-and-multiply power (up to 32 steps). Uses bsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bsm_alu
  import bsm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire alu_req_t          req_i,
  input  wire logic [DATA_W-1:0] a_i,
  input  wire logic [DATA_W-1:0] b_i,
  output alu_rsp_t               rsp_o
);

  alu_state_e state_q, state_d;

  logic [DATA_W-1:0] res_q, acc_q, base_q, rem_q, exp_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              neg_q, divz_q;

  logic              a_neg, b_neg;
  logic [DATA_W-1:0] a_mag, b_mag;
  logic [DATA_W:0]   rem_sh;
  logic              fits;
  logic [DATA_W:0]   rem_sub;
  logic [DATA_W-1:0] prod_r, prod_b, pow_res;
  logic              pow_divz;

  assign a_neg   = a_i[DATA_W-1];
  assign b_neg   = b_i[DATA_W-1];
  assign a_mag   = a_neg ? (DATA_W'(0) - a_i) : a_i;
  assign b_mag   = b_neg ? (DATA_W'(0) - b_i) : b_i;

  // one restoring division step
  assign rem_sh  = {rem_q, acc_q[DATA_W-1]};
  assign fits    = rem_sh >= {1'b0, base_q};
  assign rem_sub = rem_sh - {1'b0, base_q};

  assign prod_r  = acc_q * base_q;
  assign prod_b  = base_q * base_q;

  // negative exponent: 1 / power, truncated
  always_comb begin
    pow_res  = acc_q;
    pow_divz = 1'b0;
    if (neg_q) begin
      pow_divz = (acc_q == '0);
      if (acc_q != DATA_W'(1) && acc_q != '1) begin
        pow_res = '0;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ALU_IDLE: begin
        if (req_i.start) begin
          case (req_i.op)
            ALU_DIV: state_d = (b_i == '0) ? ALU_DONE : ALU_DIV_RUN;
            ALU_POW: state_d = ALU_POW_RUN;
            default: state_d = ALU_DONE;
          endcase
        end
      end
      ALU_DIV_RUN: if (cnt_q == '0) state_d = ALU_DONE;
      ALU_POW_RUN: if (exp_q == '0) state_d = ALU_DONE;
      ALU_DONE:    state_d = ALU_IDLE;
      default:     state_d = ALU_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp_o.done   = (state_q == ALU_DONE);
    rsp_o.divz   = divz_q;
    rsp_o.result = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ALU_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ALU_IDLE: begin
        if (req_i.start) begin
          divz_q <= 1'b0;
          case (req_i.op)
            ALU_ADD: res_q <= a_i + b_i;
            ALU_SUB: res_q <= a_i - b_i;
            ALU_MUL: res_q <= a_i * b_i;
            ALU_NEG: res_q <= DATA_W'(0) - a_i;
            ALU_DIV: begin
              divz_q <= (b_i == '0);
              res_q  <= '0;
              acc_q  <= a_mag;
              base_q <= b_mag;
              rem_q  <= '0;
              cnt_q  <= DCNT_W'(DIV_STEPS);
              neg_q  <= a_neg ^ b_neg;
            end
            ALU_POW: begin
              acc_q  <= DATA_W'(1);
              base_q <= a_i;
              exp_q  <= b_mag;
              neg_q  <= b_neg;
            end
            default: res_q <= '0;
          endcase
        end
      end
      ALU_DIV_RUN: begin
        if (cnt_q != '0) begin
          rem_q <= fits ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
          acc_q <= {acc_q[DATA_W-2:0], fits};
          cnt_q <= cnt_q - DCNT_W'(1);
        end else begin
          res_q <= neg_q ? (DATA_W'(0) - acc_q) : acc_q;
        end
      end
      ALU_POW_RUN: begin
        if (exp_q != '0) begin
          if (exp_q[0]) begin
            acc_q <= prod_r;
          end
          base_q <= prod_b;
          exp_q  <= exp_q >> 1;
        end else begin
          res_q  <= pow_res;
          divz_q <= pow_divz;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### hdl/bytecode_stack_machine_unit.sv
// Top level of the bytecode stack machine: control sequencer, operand stack
// RAM (bsm_ram) and arithmetic unit (bsm_alu). Uses bsm_pkg, assert_macros.svh.
//
// Usage:
//  - Input channel: code_byte_i with in_valid_i / in_stall_o. One program
//    byte per item; an item is taken at an edge with valid high, stall low.
//  - Output channel: value_o, status_o with out_valid_o / out_stall_i.
//    At most one result per byte: halt gives the popped value with ok,
//    any error gives value 0 with its status code and empties the stack.
//  - Steps per item: literal bytes and no-op finish when taken; an error
//    found at decode goes to emit; halt reads the top, then emits. Negate
//    reads one operand, the binary ops two, then the ALU runs; divide and
//    power run the one-bit-per-cycle divider and square-and-multiply loop.
//  - The stack lives in a RAM with one registered read port, so binary
//    ops read top then second before starting the ALU.
//  - One item is worked on at a time; in_stall_o is high while it runs.
//  - A finished result sits in a one-entry output register; the next byte
//    is taken while it waits. A second result waits in the emit state
//    until the register frees, stalling the input meanwhile.
//  - Reset empties the stack and drops any pending literal; no RAM clear.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bytecode_stack_machine_unit
  import bsm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         code_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [DATA_W-1:0] value_o,
  output logic      [2:0]         status_o
);

  ctl_state_e state_q, state_d;

  logic [CNT_W-1:0]  stack_cnt_q, cnt_m1, cnt_m2;
  logic [2:0]        lit_left_q;
  logic [23:0]       lit_part_q;
  logic [7:0]        op_q;
  logic [DATA_W-1:0] a_q, b_q, res_val_q;
  logic [2:0]        res_st_q;
  logic              out_valid_q;

  // RAM port
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  // decode of the accepted byte
  logic       accept, dec_err, dec_read, lit_push;
  logic [2:0] dec_st;
  logic       out_free;

  assign cnt_m1   = stack_cnt_q - CNT_W'(1);
  assign cnt_m2   = stack_cnt_q - CNT_W'(2);
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    dec_err  = 1'b0;
    dec_read = 1'b0;
    lit_push = 1'b0;
    dec_st   = ST_OK;
    if (lit_left_q != '0) begin
      if (lit_left_q == 3'd1) begin
        if (stack_cnt_q == STACK_FULL) begin
          dec_err = 1'b1;
          dec_st  = ST_OVER;
        end else begin
          lit_push = 1'b1;
        end
      end
    end else begin
      case (code_byte_i)
        OP_NOP, OP_LIT: ;
        OP_HALT, OP_NEG: begin
          if (stack_cnt_q == '0) begin
            dec_err = 1'b1;
            dec_st  = ST_UNDER;
          end else begin
            dec_read = 1'b1;
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW: begin
          if (stack_cnt_q < CNT_W'(2)) begin
            dec_err = 1'b1;
            dec_st  = ST_UNDER;
          end else begin
            dec_read = 1'b1;
          end
        end
        default: begin
          dec_err = 1'b1;
          dec_st  = ST_BADOP;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && dec_err) begin
          state_d = S_EMIT;
        end else if (accept && dec_read) begin
          state_d = S_RD_B;
        end
      end
      S_RD_B: state_d = S_RD_A;
      S_RD_A: begin
        case (op_q)
          OP_HALT: state_d = S_EMIT;
          OP_NEG:  state_d = S_START;
          default: state_d = S_GET_A;
        endcase
      end
      S_GET_A: state_d = S_START;
      S_START: state_d = S_EXEC;
      S_EXEC: begin
        if (alu_rsp.done) begin
          state_d = alu_rsp.divz ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o    = (state_q != S_IDLE);
    ram_we        = 1'b0;
    ram_waddr     = stack_cnt_q[ADDR_W-1:0];
    ram_wdata     = {code_byte_i, lit_part_q};
    ram_re        = 1'b0;
    ram_raddr     = cnt_m1[ADDR_W-1:0];
    alu_req.start = (state_q == S_START);
    case (op_q)
      OP_ADD:  alu_req.op = ALU_ADD;
      OP_SUB:  alu_req.op = ALU_SUB;
      OP_MUL:  alu_req.op = ALU_MUL;
      OP_DIV:  alu_req.op = ALU_DIV;
      OP_POW:  alu_req.op = ALU_POW;
      default: alu_req.op = ALU_NEG;
    endcase
    case (state_q)
      S_IDLE: ram_we = accept && lit_push;
      S_RD_B: ram_re = 1'b1;
      S_RD_A: begin
        ram_re    = (op_q != OP_HALT) && (op_q != OP_NEG);
        ram_raddr = cnt_m2[ADDR_W-1:0];
      end
      S_EXEC: begin
        ram_we    = alu_rsp.done && !alu_rsp.divz;
        ram_waddr = (op_q == OP_NEG) ? cnt_m1[ADDR_W-1:0] : cnt_m2[ADDR_W-1:0];
        ram_wdata = alu_rsp.result;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stack_cnt_q <= '0;
      lit_left_q  <= '0;
      lit_part_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (dec_err) begin
              stack_cnt_q <= '0;
              lit_left_q  <= '0;
              lit_part_q  <= '0;
            end else if (lit_left_q != '0) begin
              lit_left_q <= lit_left_q - 3'd1;
              case (lit_left_q)
                3'd4:    lit_part_q[7:0]   <= code_byte_i;
                3'd3:    lit_part_q[15:8]  <= code_byte_i;
                3'd2:    lit_part_q[23:16] <= code_byte_i;
                default: lit_part_q        <= '0;
              endcase
              if (lit_push) begin
                stack_cnt_q <= stack_cnt_q + CNT_W'(1);
              end
            end else if (code_byte_i == OP_LIT) begin
              lit_left_q <= LIT_BYTES;
              lit_part_q <= '0;
            end
          end
        end
        S_RD_A: if (op_q == OP_HALT) stack_cnt_q <= cnt_m1;
        S_EXEC: begin
          if (alu_rsp.done) begin
            if (alu_rsp.divz) begin
              stack_cnt_q <= '0;
            end else if (op_q != OP_NEG) begin
              stack_cnt_q <= cnt_m1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && out_free) begin
      value_o  <= res_val_q;
      status_o <= res_st_q;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_q      <= code_byte_i;
          res_val_q <= '0;
          res_st_q  <= dec_st;
        end
      end
      S_RD_A: begin
        b_q       <= ram_rdata;
        a_q       <= ram_rdata;
        res_val_q <= ram_rdata;
        res_st_q  <= ST_OK;
      end
      S_GET_A: a_q <= ram_rdata;
      S_EXEC: begin
        res_val_q <= '0;
        res_st_q  <= ST_DIVZ;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  bsm_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  bsm_alu u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (alu_req),
    .a_i   (a_q),
    .b_i   (b_q),
    .rsp_o (alu_rsp)
  );

  `BSM_ASSERT(a_cnt_bound, clk_i, rst_ni, stack_cnt_q <= STACK_FULL, "stack count past depth")
  `BSM_ASSERT(a_we_state, clk_i, rst_ni, ram_we |-> (state_q == S_IDLE || state_q == S_EXEC), "bad write state")
  `BSM_ASSERT(a_err_empty, clk_i, rst_ni, (state_q == S_EMIT && res_st_q != ST_OK) |-> stack_cnt_q == '0, "error left stack")
  `BSM_ASSERT_NEVER(a_alu_done, clk_i, rst_ni, alu_rsp.done && state_q != S_EXEC, "alu done while not waiting")

endmodule
`default_nettype wire

### sim/bytecode_stack_machine_unit_test.sv
// Self-checking testbench for bytecode_stack_machine_unit: drives program bytes,
// predicts halt values and error codes, compares every result. Uses bsm_pkg.
`timescale 1ns / 1ps
module bytecode_stack_machine_unit_test;
  import bsm_pkg::*;

  // Holds the predicted machine state and the queue of expected results.
  class stack_result_board;
    logic [31:0] stk [STACK_DEPTH];
    int unsigned depth;
    int unsigned lit_left;
    logic [23:0] lit_low;
    logic [31:0] exp_value [$];
    logic [2:0]  exp_status [$];
    int unsigned mismatches;

    function new();
      depth = 0;
      lit_left = 0;
      lit_low = '0;
      mismatches = 0;
    endfunction

    function void push_result(logic [31:0] v, logic [2:0] s);
      exp_value.push_back(v);
      exp_status.push_back(s);
    endfunction

    function void fault(logic [2:0] s);
      depth = 0;
      lit_left = 0;
      lit_low = '0;
      push_result('0, s);
    endfunction

    function logic [31:0] pow_wrap(logic [31:0] base, logic [31:0] e);
      logic [31:0] r;
      r = 32'd1;
      while (e != 0) begin
        if (e[0]) r = r * base;
        base = base * base;
        e = e >> 1;
      end
      return r;
    endfunction

    function logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma, mb, q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      return (a[31] != b[31]) ? -q : q;
    endfunction

    // Note one accepted program byte.
    function void take_byte(logic [7:0] cb);
      logic [31:0] a, b, r;
      if (lit_left != 0) begin
        if (lit_left > 1) begin
          lit_low = lit_low | (24'(cb) << (8 * (4 - lit_left)));
          lit_left--;
          return;
        end
        r = {cb, lit_low};
        lit_left = 0;
        lit_low = '0;
        if (depth >= STACK_DEPTH) fault(ST_OVER);
        else begin
          stk[depth] = r;
          depth++;
        end
        return;
      end
      case (cb)
        OP_NOP: ;
        OP_LIT: begin
          lit_left = LIT_BYTES;
          lit_low = '0;
        end
        OP_HALT: begin
          if (depth == 0) fault(ST_UNDER);
          else begin
            depth--;
            push_result(stk[depth], ST_OK);
          end
        end
        OP_NEG: begin
          if (depth == 0) fault(ST_UNDER);
          else stk[depth-1] = -stk[depth-1];
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW: begin
          if (depth < 2) begin
            fault(ST_UNDER);
            return;
          end
          b = stk[depth-1];
          a = stk[depth-2];
          case (cb)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            OP_DIV: begin
              if (b == 0) begin
                fault(ST_DIVZ);
                return;
              end
              r = div_trunc(a, b);
            end
            default: begin
              r = pow_wrap(a, b[31] ? -b : b);
              if (b[31]) begin
                if (r == 0) begin
                  fault(ST_DIVZ);
                  return;
                end
                if (r != 32'd1 && r != 32'hFFFF_FFFF) r = '0;
              end
            end
          endcase
          depth--;
          stk[depth-1] = r;
        end
        default: fault(ST_BADOP);
      endcase
    endfunction

    // Compare one accepted result against the oldest expectation.
    function void check_result(logic [31:0] v, logic [2:0] s);
      if (exp_value.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %h status %0d", v, s);
        return;
      end
      if (v !== exp_value[0] || s !== exp_status[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value %h status %0d, got value %h status %0d",
                   exp_value[0], exp_status[0], v, s);
      end
      void'(exp_value.pop_front());
      void'(exp_status.pop_front());
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  code_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic signed [31:0] value_o;
  logic [2:0]  status_o;

  stack_result_board board;
  bit          quiet_phase = 1'b0;
  bit          stim_done = 1'b0;
  int unsigned sent = 0;

  bytecode_stack_machine_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .code_byte_i (code_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .status_o    (status_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Hand one byte to the block; valid stays high between back-to-back bytes.
  // A random idle burst precedes some bytes unless the quiet phase is on.
  task automatic send_byte(input logic [7:0] cb);
    int unsigned gap;
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    code_byte_i <= cb;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.take_byte(cb);
    sent++;
  endtask

  task automatic send_lit(input logic [31:0] v);
    send_byte(OP_LIT);
    for (int i = 0; i < 4; i++) send_byte(v[8*i +: 8]);
  endtask

  // Operand mix: small values in -20..20, edge values and full-range noise.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'd0;
      4, 5: return $urandom();
      default: return 32'($signed($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  // Receiver side: random stall bursts, quiet near the end.
  initial begin
    int unsigned burst;
    @(posedge rst_ni);
    forever begin
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 14);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  // Result monitor: samples the values held at the edge, before its updates.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(value_o, status_o);
  end

  initial begin
    int unsigned nops;
    board = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every opcode, edge operands, underflow, divide-by-zero and bad opcode.
    send_byte(OP_HALT);                                  // underflow on empty
    send_lit(32'h8000_0000); send_lit(32'hFFFF_FFFF); send_byte(OP_DIV);
    send_byte(OP_HALT);                                  // min / -1 wraps
    send_lit(32'h7FFF_FFFF); send_byte(OP_NEG); send_byte(OP_NEG);
    send_lit(32'd1); send_byte(OP_ADD); send_byte(OP_HALT);
    send_lit(32'd3); send_lit(32'hFFFF_FFFE); send_byte(OP_POW); send_byte(OP_HALT);
    send_lit(32'd0); send_lit(32'hFFFF_FFFF); send_byte(OP_POW);  // zero power, neg exp
    send_lit(32'd5); send_lit(32'd0); send_byte(OP_DIV);          // divide by zero
    send_lit(32'hFFFF_FFFF); send_lit(32'h8000_0000); send_byte(OP_POW);
    send_lit(32'd0); send_lit(32'd0); send_byte(OP_POW); send_byte(OP_SUB);
    send_byte(OP_NOP); send_byte(8'hFF); send_byte(8'd9);         // bad opcodes
    send_lit(32'd7); send_lit(32'd6); send_byte(OP_MUL); send_byte(OP_HALT);

    // Build a deeper stack with back-to-back literals.
    for (int i = 0; i < 64; i++) begin
      quiet_phase = 1'b1;
      send_lit($urandom());
    end
    quiet_phase = 1'b0;

    // Hold off until every expected result has come.
    in_valid_i <= 1'b0;
    while (board.exp_value.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    // Random programs: mostly well-formed, some noise.
    while (sent < 1850) begin
      if (sent > 1600) quiet_phase = 1'b1;
      case ($urandom_range(0, 19))
        0: send_byte(8'($urandom_range(0, 255)));
        1: send_byte(OP_NOP);
        default: begin
          send_lit(pick_operand());
          for (int k = $urandom_range(0, 4); k > 0; k--) begin
            if ($urandom_range(0, 3) == 0) send_byte(OP_NEG);
            else begin
              send_lit(pick_operand());
              send_byte(8'($urandom_range(OP_ADD, OP_POW)));
            end
          end
          if ($urandom_range(0, 9) != 0) send_byte(OP_HALT);
          if ($urandom_range(0, 11) == 0) send_byte(OP_HALT);
        end
      endcase
    end
    in_valid_i <= 1'b0;

    while (board.exp_value.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (board.mismatches == 0 && board.exp_value.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #8000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/bsm_pkg.sv
hdl/bsm_ram.sv
hdl/bsm_alu.sv
hdl/bytecode_stack_machine_unit.sv
sim/bytecode_stack_machine_unit_test.sv
